// File: src/resume_frame_cache_unit_assert.svh
// Assertion macros shared by the checker of the resume frame cache.
// Depends on nothing; the including module supplies clk and rst.
`ifndef RESUME_FRAME_CACHE_UNIT_ASSERT_SVH
`define RESUME_FRAME_CACHE_UNIT_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define RFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define RFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/rfc_pkg.sv
// Shared types, codes and constants of the resume frame cache.
// Used by the controller, the datapath and the top level.
package rfc_pkg;

  localparam int FRAME_SLOTS_DEF  = 32;
  localparam int STREAM_SLOTS_DEF = 16;
  localparam int MAX_REPLAY       = 32;
  localparam int EW               = $clog2(MAX_REPLAY + 1);
  localparam int IN_TDATA_W       = 120;
  localparam int OUT_TDATA_W      = 136;
  localparam logic [31:0] CAPACITY_RESET = 32'd1048576;

  localparam logic [2:0] CMD_TRACK   = 3'd0;
  localparam logic [2:0] CMD_RELEASE = 3'd1;
  localparam logic [2:0] CMD_QUERY   = 3'd2;
  localparam logic [2:0] CMD_QSTREAM = 3'd3;
  localparam logic [2:0] CMD_REPLAY  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [1:0] ST_TBL_FULL = 2'd2;
  localparam logic [1:0] ST_UNAVAIL  = 2'd3;

  // release boundary source
  localparam logic [1:0] RP_POS  = 2'd0;
  localparam logic [1:0] RP_SENT = 2'd1;
  localparam logic [1:0] RP_RING = 2'd2;

  // ring read offset from head
  localparam logic [1:0] RD_HEAD = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_K    = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       rp_load;
    logic [1:0] rp_src;
    logic       s_clr;
    logic       s_inc;
    logic       s_rd;
    logic       sw_apply;
    logic       find_clr;
    logic       find_apply;
    logic       fend_rd;
    logic       rec_write;
    logic       k_clr;
    logic       k_inc;
    logic       e_clr;
    logic       e_inc;
    logic       ring_rd;
    logic [1:0] rd_sel;
    logic       pop;
    logic       rel_fin;
    logic       bytes_add;
    logic       bytes_zero;
    logic       ev_mark;
    logic       push;
    logic       sent_add;
    logic       out_load;
    logic [1:0] out_status;
    logic       out_avail;
    logic       out_entry;
  } cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       too_large;
    logic       rel_skip;
    logic       ring_empty;
    logic       count_gt1;
    logic       ring_full;
    logic       bytes_over;
    logic       ring_lt_p;
    logic       k_end;
    logic       ring_eq_pos;
    logic       pos_eq_sent;
    logic       count_same;
    logic       s_last;
    logic       found;
    logic       free_found;
    logic       has_stream;
    logic       q3_av;
    logic       rp_last;
    logic       out_free;
  } stat_t;

endpackage

// File: src/rfc_ctrl.sv
// Sequencer of the resume frame cache: walks each request through release,
// eviction, stream lookup and replay steps. Depends on rfc_pkg.
module rfc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rfc_pkg::stat_t stat,
  output rfc_pkg::cmd_t  cmd
);
  import rfc_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_REL0    = 5'd2;
  localparam logic [4:0] S_SW_RD   = 5'd3;
  localparam logic [4:0] S_SW_CHK  = 5'd4;
  localparam logic [4:0] S_RG_RD   = 5'd5;
  localparam logic [4:0] S_RG_CHK  = 5'd6;
  localparam logic [4:0] S_REL_FIN = 5'd7;
  localparam logic [4:0] S_EVCHK   = 5'd8;
  localparam logic [4:0] S_EV0     = 5'd9;
  localparam logic [4:0] S_EV1     = 5'd10;
  localparam logic [4:0] S_EV_ZERO = 5'd11;
  localparam logic [4:0] S_EV_POP  = 5'd12;
  localparam logic [4:0] S_PUSH    = 5'd13;
  localparam logic [4:0] S_F_RD    = 5'd14;
  localparam logic [4:0] S_F_CHK   = 5'd15;
  localparam logic [4:0] S_FEND_RD = 5'd16;
  localparam logic [4:0] S_FEND    = 5'd17;
  localparam logic [4:0] S_TRK_REC = 5'd18;
  localparam logic [4:0] S_AV_RD   = 5'd19;
  localparam logic [4:0] S_AV_CHK  = 5'd20;
  localparam logic [4:0] S_RP_RD   = 5'd21;
  localparam logic [4:0] S_RP_OUT  = 5'd22;
  localparam logic [4:0] S_EMIT    = 5'd23;
  localparam logic [4:0] S_BIG     = 5'd24;

  logic [4:0] state, state_next;
  logic [4:0] rel_ret, rel_ret_next;
  logic [4:0] ev_ret, ev_ret_next;
  logic [4:0] f_ret, f_ret_next;
  logic [1:0] em_st, em_st_next;
  logic       em_av, em_av_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rel_ret <= S_IDLE;
      ev_ret  <= S_IDLE;
      f_ret   <= S_IDLE;
      em_st   <= ST_OK;
      em_av   <= 1'b0;
    end else begin
      state   <= state_next;
      rel_ret <= rel_ret_next;
      ev_ret  <= ev_ret_next;
      f_ret   <= f_ret_next;
      em_st   <= em_st_next;
      em_av   <= em_av_next;
    end
  end

  always_comb begin
    cmd          = '0;
    state_next   = state;
    rel_ret_next = rel_ret;
    ev_ret_next  = ev_ret;
    f_ret_next   = f_ret;
    em_st_next   = em_st;
    em_av_next   = em_av;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        em_st_next = ST_OK;
        em_av_next = 1'b0;
        case (stat.cmd)
          CMD_TRACK: begin
            if (stat.too_large) begin
              cmd.rp_load  = 1'b1;
              cmd.rp_src   = RP_SENT;
              rel_ret_next = S_BIG;
              state_next   = S_REL0;
            end else begin
              cmd.bytes_add = 1'b1;
              state_next    = S_EVCHK;
            end
          end
          CMD_RELEASE: begin
            cmd.rp_load  = 1'b1;
            cmd.rp_src   = RP_POS;
            rel_ret_next = S_EMIT;
            state_next   = S_REL0;
          end
          CMD_QUERY, CMD_REPLAY: begin
            cmd.k_clr = 1'b1;
            if (stat.pos_eq_sent) begin
              // write position is always resumable; a replay from it is empty
              em_av_next = (stat.cmd == CMD_QUERY);
              state_next = S_EMIT;
            end else begin
              state_next = S_AV_RD;
            end
          end
          CMD_QSTREAM: begin
            cmd.find_clr = 1'b1;
            cmd.s_clr    = 1'b1;
            f_ret_next   = S_FEND_RD;
            state_next   = S_F_RD;
          end
          default: state_next = S_EMIT;
        endcase
      end
      S_BIG: begin
        cmd.sent_add = 1'b1;
        em_st_next   = ST_TOO_BIG;
        state_next   = S_EMIT;
      end
      S_REL0: begin
        if (stat.rel_skip) begin
          state_next = rel_ret;
        end else begin
          cmd.s_clr  = 1'b1;
          state_next = S_SW_RD;
        end
      end
      S_SW_RD: begin
        cmd.s_rd   = 1'b1;
        state_next = S_SW_CHK;
      end
      S_SW_CHK: begin
        cmd.sw_apply = 1'b1;
        if (stat.s_last) begin
          state_next = S_RG_RD;
        end else begin
          cmd.s_inc  = 1'b1;
          state_next = S_SW_RD;
        end
      end
      S_RG_RD: begin
        if (stat.ring_empty) begin
          state_next = S_REL_FIN;
        end else begin
          cmd.ring_rd = 1'b1;
          cmd.rd_sel  = RD_HEAD;
          state_next  = S_RG_CHK;
        end
      end
      S_RG_CHK: begin
        if (stat.ring_lt_p) begin
          cmd.pop    = 1'b1;
          state_next = S_RG_RD;
        end else begin
          state_next = S_REL_FIN;
        end
      end
      S_REL_FIN: begin
        cmd.rel_fin = 1'b1;
        state_next  = rel_ret;
      end
      S_EVCHK: begin
        if (stat.bytes_over) begin
          ev_ret_next = S_EVCHK;
          state_next  = S_EV0;
        end else if (stat.ring_full) begin
          ev_ret_next = S_PUSH;
          state_next  = S_EV0;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_EV0: begin
        cmd.ev_mark = 1'b1;
        if (stat.ring_empty) begin
          cmd.rp_load  = 1'b1;
          cmd.rp_src   = RP_SENT;
          rel_ret_next = S_EV_ZERO;
          state_next   = S_REL0;
        end else if (stat.count_gt1) begin
          cmd.ring_rd = 1'b1;
          cmd.rd_sel  = RD_NEXT;
          state_next  = S_EV1;
        end else begin
          cmd.rp_load  = 1'b1;
          cmd.rp_src   = RP_SENT;
          rel_ret_next = S_EV_POP;
          state_next   = S_REL0;
        end
      end
      S_EV1: begin
        cmd.rp_load  = 1'b1;
        cmd.rp_src   = RP_RING;
        rel_ret_next = S_EV_POP;
        state_next   = S_REL0;
      end
      S_EV_ZERO: begin
        cmd.bytes_zero = 1'b1;
        state_next     = ev_ret;
      end
      S_EV_POP: begin
        // drop the oldest frame if the release left it in place
        cmd.pop    = stat.count_same;
        state_next = ev_ret;
      end
      S_PUSH: begin
        cmd.push     = 1'b1;
        cmd.sent_add = 1'b1;
        if (stat.has_stream) begin
          cmd.find_clr = 1'b1;
          cmd.s_clr    = 1'b1;
          f_ret_next   = S_TRK_REC;
          state_next   = S_F_RD;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_F_RD: begin
        cmd.s_rd   = 1'b1;
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        cmd.find_apply = 1'b1;
        if (stat.s_last) begin
          state_next = f_ret;
        end else begin
          cmd.s_inc  = 1'b1;
          state_next = S_F_RD;
        end
      end
      S_FEND_RD: begin
        cmd.fend_rd = 1'b1;
        state_next  = S_FEND;
      end
      S_FEND: begin
        em_av_next = stat.q3_av;
        state_next = S_EMIT;
      end
      S_TRK_REC: begin
        if (stat.found || stat.free_found) begin
          cmd.rec_write = 1'b1;
        end else begin
          em_st_next = ST_TBL_FULL;
        end
        state_next = S_EMIT;
      end
      S_AV_RD: begin
        if (stat.k_end) begin
          em_st_next = (stat.cmd == CMD_REPLAY) ? ST_UNAVAIL : ST_OK;
          state_next = S_EMIT;
        end else begin
          cmd.ring_rd = 1'b1;
          cmd.rd_sel  = RD_K;
          state_next  = S_AV_CHK;
        end
      end
      S_AV_CHK: begin
        if (stat.ring_eq_pos) begin
          if (stat.cmd == CMD_REPLAY) begin
            cmd.e_clr  = 1'b1;
            state_next = S_RP_RD;
          end else begin
            em_av_next = 1'b1;
            state_next = S_EMIT;
          end
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_AV_RD;
        end
      end
      S_RP_RD: begin
        cmd.ring_rd = 1'b1;
        cmd.rd_sel  = RD_K;
        state_next  = S_RP_OUT;
      end
      S_RP_OUT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_entry  = 1'b1;
          cmd.out_status = ST_OK;
          if (stat.rp_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.k_inc  = 1'b1;
            cmd.e_inc  = 1'b1;
            state_next = S_RP_RD;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = em_st;
          cmd.out_avail  = em_av;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: src/rfc_datapath.sv
// Datapath of the resume frame cache: positions, byte count, frame ring,
// stream table, comparators and the output register. Depends on rfc_pkg.
module rfc_datapath #(
  parameter int FRAME_SLOTS  = rfc_pkg::FRAME_SLOTS_DEF,
  parameter int STREAM_SLOTS = rfc_pkg::STREAM_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [rfc_pkg::IN_TDATA_W-1:0]     in_data,
  input  logic [2:0]                         in_user,
  input  logic                               cfg_valid,
  input  logic [31:0]                        cfg_data,
  input  rfc_pkg::cmd_t                      cmd,
  output rfc_pkg::stat_t                     stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rfc_pkg::OUT_TDATA_W-1:0]    out_data,
  output logic [2:0]                         out_user,
  output logic                               out_last
);
  import rfc_pkg::*;

  localparam int IW = $clog2(FRAME_SLOTS);
  localparam int CW = $clog2(FRAME_SLOTS + 1);
  localparam int SW = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
  localparam logic [CW:0] NSLOT = (CW + 1)'(FRAME_SLOTS);

  function automatic logic [IW-1:0] ring_addr(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(off);
    if (sum >= NSLOT) sum = sum - NSLOT;
    return sum[IW-1:0];
  endfunction

  // architectural state
  logic [31:0]             capacity;
  logic [63:0]             sent;
  logic [63:0]             released;
  logic [32:0]             bytes;
  logic [IW-1:0]           head;
  logic [CW-1:0]           count;
  logic [STREAM_SLOTS-1:0] svalid;
  logic [63:0]             ring_mem [FRAME_SLOTS];
  logic [94:0]             smem [STREAM_SLOTS];

  // request and working registers
  logic [2:0]    cmd_r;
  logic [23:0]   len_r;
  logic          hs_r;
  logic [30:0]   id_r;
  logic [62:0]   pos_r;
  logic [63:0]   rel_p;
  logic          rel_skip;
  logic          rel_had;
  logic [CW-1:0] ev_before;
  logic [CW-1:0] k;
  logic [EW-1:0] e;
  logic [SW-1:0] s;
  logic          found, free_found;
  logic [SW-1:0] fidx, free_idx;
  logic [63:0]   ring_q;
  logic [IW-1:0] rd_addr_q;
  logic [94:0]   smem_q;

  // output register
  logic        o_valid;
  logic [1:0]  o_status;
  logic        o_avail, o_entry, o_last;
  logic [62:0] o_fpos, o_wpos;
  logic [4:0]  o_slot;

  logic [CW-1:0] rd_off;
  logic [IW-1:0] rd_addr, push_addr;
  logic [63:0]   rp_src_val, bound, freed;
  logic [32:0]   bytes_rel;
  logic [30:0]   s_key;
  logic [63:0]   s_end;
  logic [SW-1:0] widx;

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD: rd_off = '0;
      RD_NEXT: rd_off = CW'(1);
      default: rd_off = k;
    endcase
    case (cmd.rp_src)
      RP_POS:  rp_src_val = {1'b0, pos_r};
      RP_SENT: rp_src_val = sent;
      default: rp_src_val = ring_q;
    endcase
  end

  assign rd_addr   = ring_addr(head, rd_off);
  assign push_addr = ring_addr(head, count);
  assign s_key     = smem_q[94:64];
  assign s_end     = smem_q[63:0];
  assign widx      = found ? fidx : free_idx;

  // bytes freed by moving the released boundary
  assign bound     = (count == '0) ? rel_p : ring_q;
  assign freed     = (bound >= released) ? (bound - released) : 64'd0;
  assign bytes_rel = (freed >= {31'd0, bytes}) ? 33'd0 : (bytes - freed[32:0]);

  always_comb begin
    stat             = '0;
    stat.cmd         = cmd_r;
    stat.too_large   = {8'd0, len_r} > capacity;
    stat.rel_skip    = rel_skip;
    stat.ring_empty  = (count == '0);
    stat.count_gt1   = (count > CW'(1));
    stat.ring_full   = (count >= CW'(FRAME_SLOTS));
    stat.bytes_over  = (bytes > {1'b0, capacity});
    stat.ring_lt_p   = (ring_q < rel_p);
    stat.k_end       = (k == count);
    stat.ring_eq_pos = (ring_q == {1'b0, pos_r});
    stat.pos_eq_sent = (sent == {1'b0, pos_r});
    stat.count_same  = (count == ev_before);
    stat.s_last      = (s == SW'(STREAM_SLOTS - 1));
    stat.found       = found;
    stat.free_found  = free_found;
    stat.has_stream  = hs_r;
    stat.q3_av       = found ? (s_end <= {1'b0, pos_r}) : (released >= {1'b0, pos_r});
    stat.rp_last     = (({1'b0, k} + 1'b1) == {1'b0, count}) ||
                       (e == EW'(MAX_REPLAY - 1));
    stat.out_free    = !o_valid || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
      sent     <= '0;
      released <= '0;
      bytes    <= '0;
      head     <= '0;
      count    <= '0;
      svalid   <= '0;
      o_valid  <= 1'b0;
    end else begin
      if (cfg_valid) capacity <= cfg_data;
      if (cmd.sent_add) sent <= sent + {40'd0, len_r};
      if (cmd.rel_fin) begin
        released <= rel_p;
        if (rel_had) bytes <= bytes_rel;
      end
      if (cmd.bytes_add) bytes <= bytes + {9'd0, len_r};
      if (cmd.bytes_zero) bytes <= '0;
      if (cmd.pop) begin
        head  <= ring_addr(head, CW'(1));
        count <= count - CW'(1);
      end
      if (cmd.push) count <= count + CW'(1);
      if (cmd.sw_apply && svalid[s] && (s_end <= rel_p)) svalid[s] <= 1'b0;
      if (cmd.rec_write) svalid[widx] <= 1'b1;
      if (cmd.out_load) o_valid <= 1'b1;
      else if (out_ready) o_valid <= 1'b0;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_user;
      len_r <= in_data[23:0];
      hs_r  <= in_data[24];
      id_r  <= in_data[55:25];
      pos_r <= in_data[118:56];
    end
    if (cmd.rp_load) begin
      rel_p    <= (rp_src_val > sent) ? sent : rp_src_val;
      rel_skip <= (rp_src_val <= released);
      rel_had  <= (count != '0);
    end
    if (cmd.ev_mark) ev_before <= count;
    if (cmd.k_clr) k <= '0;
    else if (cmd.k_inc) k <= k + CW'(1);
    if (cmd.e_clr) e <= '0;
    else if (cmd.e_inc) e <= e + EW'(1);
    if (cmd.s_clr) s <= '0;
    else if (cmd.s_inc) s <= s + SW'(1);
    if (cmd.find_clr) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.find_apply) begin
      if (svalid[s] && (s_key == id_r) && !found) begin
        found <= 1'b1;
        fidx  <= s;
      end
      if (!svalid[s] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= s;
      end
    end
    if (cmd.out_load) begin
      o_status <= cmd.out_status;
      o_avail  <= cmd.out_avail;
      o_entry  <= cmd.out_entry;
      o_wpos   <= sent[62:0];
      o_fpos   <= cmd.out_entry ? ring_q[62:0] : 63'd0;
      o_slot   <= cmd.out_entry ? 5'(rd_addr_q) : 5'd0;
      o_last   <= cmd.out_entry ? stat.rp_last : 1'b1;
    end
  end

  // frame ring
  always_ff @(posedge clk) begin
    if (cmd.push) ring_mem[push_addr] <= sent;
    if (cmd.ring_rd) begin
      ring_q    <= ring_mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // stream table: key over end position
  always_ff @(posedge clk) begin
    if (cmd.rec_write) smem[widx] <= {id_r, sent};
    if (cmd.s_rd) smem_q <= smem[s];
    else if (cmd.fend_rd) smem_q <= smem[fidx];
  end

  assign out_valid = o_valid;
  assign out_data  = {4'd0, o_wpos, o_slot, o_fpos, o_avail};
  assign out_user  = {o_entry, o_status};
  assign out_last  = o_last;

endmodule

// File: src/resume_frame_cache_unit.sv
// Resume frame cache: one request at a time, result in a skid-free output register.
// Stream table and ring walks visit one entry at a time: a release that moves the
// boundary walks every stream slot and the ring frames below it, and a track may
// evict frames before its push. A replay gives one result per frame, up to MAX_REPLAY,
// and holds while the output register is full; a new request waits for the last result.
// Reset (synchronous, rst high) empties ring and stream table, loads capacity 1048576.
module resume_frame_cache_unit #(
  parameter int FRAME_SLOTS  = rfc_pkg::FRAME_SLOTS_DEF,
  parameter int STREAM_SLOTS = rfc_pkg::STREAM_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // frame_length, has_stream, stream_id, position, pad
  input  logic [rfc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [2:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // available, frame_position, frame_slot, write_position, pad
  output logic [rfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status, entry_valid
  output logic [2:0]                      m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [31:0]                     cfg_data
);
  import rfc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  rfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rfc_datapath #(
    .FRAME_SLOTS  (FRAME_SLOTS),
    .STREAM_SLOTS (STREAM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

// File: src/rfc_checker.sv
// Port-level checks of the resume frame cache, bound to the top level.
// Depends on rfc_pkg and resume_frame_cache_unit_assert.svh.
`include "resume_frame_cache_unit_assert.svh"
module rfc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [2:0]                      m_axis_tuser,
  input logic                            m_axis_tlast
);
  import rfc_pkg::*;

  `RFC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `RFC_ASSERT_IMP(a_single_last, m_axis_tvalid && !m_axis_tuser[2], m_axis_tlast, "non-replay result without last")
  `RFC_ASSERT_IMP(a_entry_ok, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == ST_OK, "replayed frame with error status")
  `RFC_ASSERT_IMP(a_entry_noavail, m_axis_tvalid && m_axis_tuser[2], !m_axis_tdata[0], "replayed frame flags availability")

endmodule

bind resume_frame_cache_unit rfc_checker u_rfc_checker (.*);

// File: verif/tb_top.sv
// Self-checking bench for resume_frame_cache_unit: directed and random requests,
// predicted results compared on the output stream. Depends on rfc_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
  import rfc_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int NSLOT = FRAME_SLOTS_DEF;
  localparam int NSTRM = STREAM_SLOTS_DEF;
  localparam int STALL_LIMIT = 10000;
  localparam int SETTLE = 4 * NSTRM + 3 * NSLOT + 40;

  typedef struct packed {
    logic [1:0]  status;
    logic        available;
    logic        entry_valid;
    logic [62:0] frame_position;
    logic [4:0]  frame_slot;
    logic        last;
    logic [62:0] write_position;
  } cache_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  resume_frame_cache_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mirror of the cache state
  logic [31:0] cap_m;
  logic [63:0] sent_pos, rel_pos, bytes_used;
  logic [63:0] frame_start [NSLOT];
  int          head, count;
  bit          strm_valid [NSTRM];
  logic [30:0] strm_key [NSTRM];
  logic [63:0] strm_end [NSTRM];

  cache_result_t expected_results [$];
  int errors = 0;
  int snd_idle_pct = 0, rcv_stall_pct = 0, hold_off = 0, stall_cycles = 0;

  function automatic int slot_at(int k);
    return (head + k) % NSLOT;
  endfunction

  task automatic release_upto(logic [63:0] p);
    int k;
    logic [63:0] bound, freed;
    if (p <= rel_pos) return;
    if (p > sent_pos) p = sent_pos;
    for (int s = 0; s < NSTRM; s++)
      if (strm_valid[s] && strm_end[s] <= p) strm_valid[s] = 0;
    if (count != 0) begin
      k = 0;
      while (k < count && frame_start[slot_at(k)] < p) k++;
      bound = (k == count) ? p : frame_start[slot_at(k)];
      freed = (bound >= rel_pos) ? bound - rel_pos : 64'd0;
      bytes_used = (freed >= bytes_used) ? 64'd0 : bytes_used - freed;
      head = slot_at(k);
      count -= k;
    end
    rel_pos = p;
  endtask

  task automatic evict_oldest();
    int was;
    was = count;
    if (count == 0) begin
      release_upto(sent_pos);
      bytes_used = 0;
      return;
    end
    release_upto((count > 1) ? frame_start[slot_at(1)] : sent_pos);
    if (count == was) begin
      head = slot_at(1);
      count--;
    end
  endtask

  function automatic bit resumable(logic [63:0] p);
    if (p == sent_pos) return 1;
    for (int k = 0; k < count; k++)
      if (frame_start[slot_at(k)] == p) return 1;
    return 0;
  endfunction

  function automatic int stream_lookup(logic [30:0] id);
    for (int s = 0; s < NSTRM; s++)
      if (strm_valid[s] && strm_key[s] == id) return s;
    return -1;
  endfunction

  task automatic push_result(logic [1:0] st, logic av, logic ev, logic [63:0] fp,
                             int fs, logic lst);
    cache_result_t r;
    r.status = st; r.available = av; r.entry_valid = ev;
    r.frame_position = fp[62:0]; r.frame_slot = fs[4:0]; r.last = lst;
    r.write_position = sent_pos[62:0];
    expected_results.push_back(r);
  endtask

  task automatic predict_request(logic [2:0] cmd, logic [23:0] len, logic hs,
                                 logic [30:0] id, logic [62:0] pos);
    logic [63:0] p;
    logic [1:0] st;
    int e, k, n;
    p = {1'b0, pos};
    case (cmd)
      CMD_TRACK: begin
        if ({40'd0, len} > {32'd0, cap_m}) begin
          release_upto(sent_pos);
          sent_pos += len;
          push_result(ST_TOO_BIG, 0, 0, 0, 0, 1);
        end else begin
          st = ST_OK;
          bytes_used += len;
          while (bytes_used > {32'd0, cap_m}) evict_oldest();
          if (count >= NSLOT) evict_oldest();
          frame_start[slot_at(count)] = sent_pos;
          count++;
          sent_pos += len;
          if (hs) begin
            e = stream_lookup(id);
            for (int s = 0; s < NSTRM && e < 0; s++)
              if (!strm_valid[s]) e = s;
            if (e < 0) st = ST_TBL_FULL;
            else begin
              strm_valid[e] = 1; strm_key[e] = id; strm_end[e] = sent_pos;
            end
          end
          push_result(st, 0, 0, 0, 0, 1);
        end
      end
      CMD_RELEASE: begin
        release_upto(p);
        push_result(ST_OK, 0, 0, 0, 0, 1);
      end
      CMD_QUERY: push_result(ST_OK, resumable(p), 0, 0, 0, 1);
      CMD_QSTREAM: begin
        e = stream_lookup(id);
        push_result(ST_OK, (e >= 0) ? (strm_end[e] <= p) : (rel_pos >= p), 0, 0, 0, 1);
      end
      CMD_REPLAY: begin
        if (!resumable(p)) push_result(ST_UNAVAIL, 0, 0, 0, 0, 1);
        else if (p == sent_pos) push_result(ST_OK, 0, 0, 0, 0, 1);
        else begin
          k = 0;
          while (k < count && frame_start[slot_at(k)] < p) k++;
          n = count - k;
          if (n > MAX_REPLAY) n = MAX_REPLAY;
          for (int i = 0; i < n; i++)
            push_result(ST_OK, 0, 1, frame_start[slot_at(k + i)], slot_at(k + i),
                        i == n - 1);
        end
      end
      default: push_result(ST_OK, 0, 0, 0, 0, 1);
    endcase
  endtask

  task automatic send_request(logic [2:0] cmd, logic [23:0] len = 0, logic hs = 0,
                              logic [30:0] id = 0, logic [62:0] pos = 0);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tdata = {1'b0, pos, id, hs, len};
    s_axis_tuser = cmd;
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_request(cmd, len, hs, id, pos);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drain();
    drop_valid();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(logic [31:0] v);
    wait_drain();
    @(negedge clk);
    cfg_data = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_m = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    cache_result_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.available = m_axis_tdata[0];
      got.frame_position = m_axis_tdata[63:1];
      got.frame_slot = m_axis_tdata[68:64];
      got.write_position = m_axis_tdata[131:69];
      got.status = m_axis_tuser[1:0];
      got.entry_valid = m_axis_tuser[2];
      got.last = m_axis_tlast;
      if (expected_results.size() == 0) report_mismatch("unexpected result", 0, 0);
      else begin
        want = expected_results.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.available != want.available)
          report_mismatch("available", got.available, want.available);
        if (got.entry_valid != want.entry_valid)
          report_mismatch("entry_valid", got.entry_valid, want.entry_valid);
        if (got.frame_position != want.frame_position)
          report_mismatch("frame_position", got.frame_position, want.frame_position);
        if (got.frame_slot != want.frame_slot)
          report_mismatch("frame_slot", got.frame_slot, want.frame_slot);
        if (got.last != want.last) report_mismatch("last", got.last, want.last);
        if (got.write_position != want.write_position)
          report_mismatch("write_position", got.write_position, want.write_position);
      end
    end
  end

  // result-side back-pressure, with a long hold while hold_off counts down
  always @(negedge clk) begin
    if (hold_off > 0) begin
      m_axis_tready = 1'b0;
      hold_off--;
    end else
      m_axis_tready = ($urandom_range(99) >= rcv_stall_pct);
  end

  // watchdog: cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else if (++stall_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic logic [62:0] pick_position();
    int r;
    r = $urandom_range(99);
    if (r < 40 && count > 0) return frame_start[slot_at($urandom_range(count - 1))][62:0];
    if (r < 60) return sent_pos[62:0];
    if (r < 80) return sent_pos[62:0] - 63'($urandom_range(400));
    return 63'({$urandom, $urandom});
  endfunction

  task automatic test_directed();
    send_request(CMD_QUERY, 0, 0, 0, 0);
    send_request(CMD_REPLAY, 0, 0, 0, 0);                 // idle replay
    send_request(CMD_QSTREAM, 0, 0, 31'h7FFFFFFF, 0);
    send_request(CMD_TRACK, 0, 1, 31'h7FFFFFFF, 0);
    send_request(CMD_TRACK, 100, 1, 31'd5, 0);
    send_request(CMD_TRACK, 200, 0, 0, 0);
    send_request(CMD_TRACK, 24'hFFFFFF, 1, 31'd6, 0);    // too large for capacity
    send_request(CMD_TRACK, 50, 1, 31'd5, 0);
    send_request(CMD_QSTREAM, 0, 0, 31'd5, 63'd0);
    send_request(CMD_QSTREAM, 0, 0, 31'd5, sent_pos[62:0]);
    send_request(CMD_QUERY, 0, 0, 0, 63'd7);
    send_request(CMD_REPLAY, 0, 0, 0, 63'd7);              // unavailable
    send_request(CMD_REPLAY, 0, 0, 0, frame_start[slot_at(0)][62:0]);
    send_request(CMD_RELEASE, 0, 0, 0, 63'h7FFFFFFFFFFFFFFF);
    send_request(CMD_RELEASE, 0, 0, 0, 63'd0);             // below boundary, ignored
    send_request(CMD_QUERY, 0, 0, 0, 63'h7FFFFFFFFFFFFFFF);
    send_request(CMD_QSTREAM, 0, 0, 31'd9, 63'h7FFFFFFFFFFFFFFF);
    for (logic [3:0] c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
      send_request(c[2:0], 24'hFFFFFF, 1, 31'h7FFFFFFF, 63'h7FFFFFFFFFFFFFFF);
    wait_drain();
  endtask

  task automatic test_stream_table_full();
    for (int i = 0; i < NSTRM + 3; i++) send_request(CMD_TRACK, 10, 1, 31'(1000 + i), 0);
    send_request(CMD_QSTREAM, 0, 0, 31'd1000, sent_pos[62:0]);
    send_request(CMD_RELEASE, 0, 0, 0, sent_pos[62:0]);
    wait_drain();
  endtask

  task automatic test_ring_full();
    for (int i = 0; i < NSLOT + 3; i++) send_request(CMD_TRACK, 24'(1 + i), 0, 0, 0);
    send_request(CMD_REPLAY, 0, 0, 0, frame_start[slot_at(0)][62:0]);
    send_request(CMD_REPLAY, 0, 0, 0, frame_start[slot_at(count - 1)][62:0]);
    wait_drain();
  endtask

  task automatic test_capacity();
    write_capacity(32'd0);
    send_request(CMD_TRACK, 1, 1, 31'd3, 0);
    send_request(CMD_TRACK, 0, 1, 31'd3, 0);
    send_request(CMD_REPLAY, 0, 0, 0, pick_position());
    write_capacity(32'd120);
    for (int i = 0; i < 12; i++) send_request(CMD_TRACK, 24'($urandom_range(60)), 0, 0, 0);
    send_request(CMD_REPLAY, 0, 0, 0, frame_start[slot_at(0)][62:0]);
    write_capacity(32'hFFFFFFFF);
    send_request(CMD_TRACK, 24'hFFFFFF, 0, 0, 0);
    send_request(CMD_TRACK, 24'hABCDEF, 1, 31'h2AAAAAAA, 0);
  endtask

  task automatic test_random(int n);
    int r;
    logic [2:0] cmd;
    logic [23:0] len;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      cmd = (r < 45) ? CMD_TRACK : (r < 58) ? CMD_RELEASE : (r < 72) ? CMD_QUERY :
            (r < 82) ? CMD_QSTREAM : (r < 97) ? CMD_REPLAY :
            3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      len = ($urandom_range(19) == 0) ? 24'($urandom) : 24'($urandom_range(400));
      send_request(cmd, len, 1'($urandom),
                   ($urandom_range(4) == 0) ? 31'($urandom) : 31'($urandom_range(23)),
                   pick_position());
    end
  endtask

  initial begin
    cap_m = CAPACITY_RESET;
    sent_pos = 0; rel_pos = 0; bytes_used = 0; head = 0; count = 0;
    foreach (strm_valid[s]) strm_valid[s] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_stream_table_full();
    test_ring_full();
    test_capacity();

    write_capacity(32'd3000);
    test_random(45);
    snd_idle_pct = 77;
    test_random(45);
    wait_drain();                     // sender waits for every result
    snd_idle_pct = 0; rcv_stall_pct = 77;
    hold_off = 400;                   // long hold while requests keep coming
    test_random(45);
    write_capacity(32'd900);
    snd_idle_pct = 17; rcv_stall_pct = 17;
    test_random(45);
    snd_idle_pct = 0; rcv_stall_pct = 0;
    test_random(45);

    wait_drain();
    if (errors == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/rfc_pkg.sv
src/rfc_ctrl.sv
src/rfc_datapath.sv
src/resume_frame_cache_unit.sv
src/rfc_checker.sv
verif/tb_top.sv
